/* rtl/core/fscf_pkg.sv */
package fscf_pkg;

  localparam int SIZE_BITS = 20;
  localparam int NDIG      = (SIZE_BITS + 3) / 4;

  // result slots of one transaction, in output order
  localparam int P_HCR  = NDIG;
  localparam int P_HLF  = NDIG + 1;
  localparam int P_DATA = NDIG + 2;
  localparam int P_PAD  = NDIG + 3;
  localparam int P_TCR  = NDIG + 4;
  localparam int P_TLF  = NDIG + 5;
  localparam int P_FIN  = NDIG + 6;
  localparam int NFIN   = 5;
  localparam int NPOS   = P_FIN + NFIN;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [SIZE_BITS-1:0] CFG_RESET = SIZE_BITS'(1024);

  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_OPEN  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  localparam logic [7:0] CR_BYTE    = 8'h0d;
  localparam logic [7:0] LF_BYTE    = 8'h0a;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] ZERO_BYTE  = 8'h30;

  typedef struct packed {
    logic [NPOS-1:0]      mask;
    logic [SIZE_BITS-1:0] size;
    logic [7:0]           data;
    logic [SIZE_BITS-1:0] pad;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = ZERO_BYTE + {4'h0, n};
    end else begin
      r = 8'h57 + {4'h0, n};
    end
    return r;
  endfunction

endpackage

/* rtl/core/fscf_front.sv */
module fscf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    req_type_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          cfg_we_i,
  input  logic [fscf_pkg::SIZE_BITS-1:0] cfg_wdata_i,
  output logic                          push_o,
  output fscf_pkg::job_t                job_o
);
  import fscf_pkg::*;

  logic [SIZE_BITS-1:0] cfg_q, cfg_d;
  logic [SIZE_BITS-1:0] room_q, room_d;
  logic                 open_q, open_d;
  logic [SIZE_BITS-1:0] eff, eff_new, room_cur, room_dec;
  logic [NDIG*4-1:0]    epad;
  logic [NPOS-1:0]      hdr_mask;

  assign eff     = (cfg_q == '0) ? SIZE_BITS'(1) : cfg_q;
  assign eff_new = (cfg_wdata_i == '0) ? SIZE_BITS'(1) : cfg_wdata_i;
  assign epad    = (NDIG*4)'(eff);

  always_comb begin
    hdr_mask = '0;
    for (int k = 0; k < NDIG; k++) begin
      hdr_mask[k] = (k == NDIG - 1) || ((epad >> (4 * (NDIG - 1 - k))) != '0);
    end
    hdr_mask[P_HCR] = 1'b1;
    hdr_mask[P_HLF] = 1'b1;
  end

  assign room_cur = open_q ? room_q : eff;
  assign room_dec = room_cur - SIZE_BITS'(1);

  always_comb begin
    job_o      = '0;
    job_o.size = eff;
    job_o.data = data_byte_i;
    job_o.pad  = room_q;
    push_o     = 1'b0;
    open_d     = open_q;
    room_d     = room_q;
    cfg_d      = cfg_q;
    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
      if (!open_q) begin
        room_d = eff_new;
      end
    end
    if (accept_i) begin
      case (req_type_i)
        REQ_DATA: begin
          push_o = 1'b1;
          if (!open_q) begin
            job_o.mask = hdr_mask;
          end
          job_o.mask[P_DATA] = 1'b1;
          if (room_dec == '0) begin
            job_o.mask[P_TCR] = 1'b1;
            job_o.mask[P_TLF] = 1'b1;
            open_d = 1'b0;
            room_d = eff;
          end else begin
            open_d = 1'b1;
            room_d = room_dec;
          end
        end
        REQ_OPEN: begin
          if (!open_q) begin
            push_o     = 1'b1;
            job_o.mask = hdr_mask;
            open_d     = 1'b1;
            room_d     = eff;
          end
        end
        REQ_CLOSE: begin
          push_o = 1'b1;
          if (open_q) begin
            job_o.mask[P_PAD] = (room_q != '0);
            job_o.mask[P_TCR] = 1'b1;
            job_o.mask[P_TLF] = 1'b1;
            open_d = 1'b0;
            room_d = eff;
          end
          job_o.mask[P_FIN +: NFIN] = '1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= CFG_RESET;
      room_q <= CFG_RESET;
      open_q <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      room_q <= room_d;
      open_q <= open_d;
    end
  end

endmodule

/* rtl/core/fscf_queue.sv */
module fscf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fscf_pkg::job_t push_data_i,
  input  logic           pop_i,
  output fscf_pkg::job_t head_o,
  output logic           valid_o,
  output logic           full_o
);
  import fscf_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/fscf_back.sv */
module fscf_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fscf_pkg::job_t                 head_i,
  input  logic                           head_valid_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic [fscf_pkg::SIZE_BITS-1:0] repeat_count_o,
  output logic                           run_last_o
);
  import fscf_pkg::*;

  job_t                 job_q;
  logic [NPOS-1:0]      rem_q;
  logic                 valid_q;
  logic [7:0]           byte_q, byte_d;
  logic [SIZE_BITS-1:0] cnt_q, cnt_d;
  logic                 last_q;
  job_t                 src;
  logic [NPOS-1:0]      src_mask, sel, rest;
  logic [NDIG*4-1:0]    spad;
  logic                 can_load, use_head, emit;

  assign can_load = !valid_q || out_ready_i;
  assign use_head = (rem_q == '0) && head_valid_i;
  assign emit     = can_load && ((rem_q != '0) || head_valid_i);
  assign pop_o    = can_load && use_head;

  assign src      = use_head ? head_i : job_q;
  assign src_mask = use_head ? head_i.mask : rem_q;
  assign sel      = src_mask & (~src_mask + NPOS'(1));
  assign rest     = src_mask & ~sel;
  assign spad     = (NDIG*4)'(src.size);

  always_comb begin
    byte_d = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (sel[k]) begin
        byte_d = hex_char(spad[4 * (NDIG - 1 - k) +: 4]);
      end
    end
    if (sel[P_DATA]) begin
      byte_d = src.data;
    end
    if (sel[P_PAD]) begin
      byte_d = SPACE_BYTE;
    end
    if (sel[P_HCR] || sel[P_TCR] || sel[P_FIN+1] || sel[P_FIN+3]) begin
      byte_d = CR_BYTE;
    end
    if (sel[P_HLF] || sel[P_TLF] || sel[P_FIN+2] || sel[P_FIN+4]) begin
      byte_d = LF_BYTE;
    end
    if (sel[P_FIN]) begin
      byte_d = ZERO_BYTE;
    end
    cnt_d = sel[P_PAD] ? src.pad : SIZE_BITS'(1);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
    if (emit) begin
      byte_q <= byte_d;
      cnt_q  <= cnt_d;
      last_q <= (rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (emit) begin
        rem_q   <= rest;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign repeat_count_o = cnt_q;
  assign run_last_o     = last_q;

endmodule

/* rtl/core/fixed_size_chunk_framer.sv */
// Fixed-size chunk framer: encodes a byte stream as HTTP/1.1 chunked transfer coding in which
// every chunk has the configured size. One result leaves per cycle from the output register
// while the output is ready. An item causes 1 result for a byte inside a chunk, 3 for a
// byte that fills one, up to 8 for a byte that opens a chunk with a five-digit size or for a
// close of an open chunk, none for an empty write on an open chunk or an unused request, so
// the back sequencer's one result per cycle sets the sustained rate. Items are classified on
// acceptance and wait in a two-entry queue, so the input keeps taking transactions while the
// output stalls until that queue fills. The chunk size register may only be written while the
// block is idle.
module fixed_size_chunk_framer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     req_type_i,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic [fscf_pkg::SIZE_BITS-1:0] repeat_count_o,
  output logic                           run_last_o,
  input  logic                           cfg_we_i,
  input  logic [fscf_pkg::SIZE_BITS-1:0] cfg_wdata_i
);
  import fscf_pkg::*;

  logic accept, push, pop, q_valid, q_full;
  job_t push_job, head_job;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  fscf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push),
    .job_o       (push_job)
  );

  fscf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .valid_o     (q_valid),
    .full_o      (q_full)
  );

  fscf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_job),
    .head_valid_i   (q_valid),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .repeat_count_o (repeat_count_o),
    .run_last_o     (run_last_o)
  );

`ifndef ASSERT_OFF
  // a run longer than one is only ever space padding
  a_run_is_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (repeat_count_o != SIZE_BITS'(1)) |-> (out_byte_o == SPACE_BYTE))
    else $error("repeated byte is not padding");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (repeat_count_o != '0))
    else $error("zero repeat count");

  // a stalled result holds until taken
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(repeat_count_o) && $stable(run_last_o))
    else $error("result changed while stalled");
`endif

endmodule

/* bench/fixed_size_chunk_framer_tb.sv */
`timescale 1ns / 100ps

module fixed_size_chunk_framer_tb;
  import fscf_pkg::*;

  localparam int                   HALF_PERIOD    = 4;
  localparam int                   WATCHDOG_LIMIT = 5000;
  localparam int                   SETTLE_CYCLES  = 24;
  localparam logic  [1:0]          REQ_UNUSED     = 2'd3;
  localparam logic [SIZE_BITS-1:0] ONE_RUN        = SIZE_BITS'(1);

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] data;
  } frame_req_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [SIZE_BITS-1:0] count;
    logic                 last;
  } enc_byte_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           req_type_i   = REQ_DATA;
  logic [7:0]           data_byte_i  = 8'h00;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [7:0]           out_byte_o;
  logic [SIZE_BITS-1:0] repeat_count_o;
  logic                 run_last_o;
  logic                 cfg_we_i     = 1'b0;
  logic [SIZE_BITS-1:0] cfg_wdata_i  = '0;

  frame_req_t           req_queue[$];
  enc_byte_t            enc_expected[$];
  logic [SIZE_BITS-1:0] model_size = CFG_RESET;
  logic [SIZE_BITS-1:0] model_room = CFG_RESET;
  logic                 model_open = 1'b0;
  int unsigned          send_idle_pct = 9;
  int unsigned          recv_idle_pct = 63;
  logic                 in_taken = 1'b0;
  int                   errors = 0;
  int                   stall_cycles = 0;

  fixed_size_chunk_framer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .repeat_count_o (repeat_count_o),
    .run_last_o     (run_last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
    return (s == '0) ? SIZE_BITS'(1) : s;
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
  endfunction

  function automatic void push_enc(input logic [7:0] b, input logic [SIZE_BITS-1:0] c);
    enc_byte_t e;
    e.out_byte = b;
    e.count    = c;
    e.last     = 1'b0;
    enc_expected.push_back(e);
  endfunction

  function automatic void encode_item(input logic [1:0] req, input logic [7:0] data);
    int          first_idx;
    int unsigned s;
    int          nd;
    int          k;
    first_idx = enc_expected.size();
    if (req == REQ_DATA || req == REQ_OPEN) begin
      if (!model_open) begin
        model_room = eff_size(model_size);
        s = 32'(eff_size(model_size));
        nd = 1;
        while (nd < NDIG && (s >> (4 * nd)) != 0) nd++;
        for (k = nd - 1; k >= 0; k--) begin
          push_enc(hex_ascii(4'(s >> (4 * k))), ONE_RUN);
        end
        push_enc(CR_BYTE, ONE_RUN);
        push_enc(LF_BYTE, ONE_RUN);
        model_open = 1'b1;
      end
      if (req == REQ_DATA) begin
        push_enc(data, ONE_RUN);
        model_room = model_room - ONE_RUN;
        if (model_room == '0) begin
          push_enc(CR_BYTE, ONE_RUN);
          push_enc(LF_BYTE, ONE_RUN);
          model_open = 1'b0;
          model_room = eff_size(model_size);
        end
      end
    end else if (req == REQ_CLOSE) begin
      if (model_open) begin
        if (model_room != '0) push_enc(SPACE_BYTE, model_room);
        push_enc(CR_BYTE, ONE_RUN);
        push_enc(LF_BYTE, ONE_RUN);
        model_open = 1'b0;
        model_room = eff_size(model_size);
      end
      push_enc(ZERO_BYTE, ONE_RUN);
      push_enc(CR_BYTE, ONE_RUN);
      push_enc(LF_BYTE, ONE_RUN);
      push_enc(CR_BYTE, ONE_RUN);
      push_enc(LF_BYTE, ONE_RUN);
    end
    if (enc_expected.size() > first_idx) begin
      enc_expected[enc_expected.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_type_i  <= req_queue[0].req;
        data_byte_i <= req_queue[0].data;
        in_valid_i  <= 1'b1;
        void'(req_queue.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    enc_byte_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) encode_item(req_type_i, data_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (enc_expected.size() == 0) begin
          $display("%0t: unexpected transaction, expected none actual %h x%0d last %b",
                   $time, out_byte_o, repeat_count_o, run_last_o);
          errors++;
        end else begin
          want = enc_expected.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(out_byte_o));
          check_field("repeat_count", 32'(want.count), 32'(repeat_count_o));
          check_field("run_last", 32'(want.last), 32'(run_last_o));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic add_item(input logic [1:0] req, input logic [7:0] data);
    frame_req_t it;
    it.req  = req;
    it.data = data;
    req_queue.push_back(it);
  endtask

  task automatic drain();
    while (req_queue.size() != 0 || in_valid_i || enc_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_BITS-1:0] v);
    @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    model_size = v;
    if (!model_open) model_room = eff_size(v);
  endtask

  initial begin
    int unsigned          roll;
    logic [SIZE_BITS-1:0] size_sel;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset size, extremes of data, open on open chunk, unused request, close twice
    add_item(REQ_DATA, 8'h00);
    add_item(REQ_DATA, 8'hff);
    add_item(REQ_OPEN, 8'h00);
    add_item(REQ_UNUSED, 8'h5a);
    add_item(REQ_CLOSE, 8'h00);
    add_item(REQ_CLOSE, 8'hff);
    drain();
    // size change while a chunk is open
    write_size(20'd3);
    add_item(REQ_DATA, 8'h11);
    add_item(REQ_OPEN, 8'h00);
    add_item(REQ_DATA, 8'h22);
    drain();
    write_size(20'd2);
    add_item(REQ_DATA, 8'h33);
    add_item(REQ_DATA, 8'h44);
    add_item(REQ_CLOSE, 8'h00);
    drain();
    // zero size behaves as one
    write_size('0);
    add_item(REQ_OPEN, 8'h00);
    add_item(REQ_DATA, 8'h5a);
    add_item(REQ_DATA, 8'hc3);
    add_item(REQ_UNUSED, 8'ha5);
    add_item(REQ_CLOSE, 8'h00);
    drain();
    write_size('1);
    add_item(REQ_DATA, 8'h80);
    add_item(REQ_DATA, 8'h7f);
    add_item(REQ_CLOSE, 8'h00);
    drain();
    write_size(20'd1);
    add_item(REQ_OPEN, 8'h00);
    add_item(REQ_CLOSE, 8'h00);

    for (int m = 0; m < 3; m++) begin
      for (int p = 0; p < 5; p++) begin
        drain();
        if (m == 1) begin
          send_idle_pct = 63;
          recv_idle_pct = 9;
        end else if (m == 2) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        case ($urandom_range(9))
          0:       size_sel = '0;
          1:       size_sel = 20'd1;
          2:       size_sel = '1;
          3:       size_sel = SIZE_BITS'($urandom);
          default: size_sel = SIZE_BITS'($urandom_range(12, 2));
        endcase
        write_size(size_sel);
        repeat (29) begin
          roll = $urandom_range(99);
          if (roll < 80) begin
            add_item(REQ_DATA, 8'($urandom_range(255)));
          end else if (roll < 87) begin
            add_item(REQ_OPEN, 8'($urandom_range(255)));
          end else if (roll < 95) begin
            add_item(REQ_CLOSE, 8'($urandom_range(255)));
          end else begin
            add_item(REQ_UNUSED, 8'($urandom_range(255)));
          end
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/fscf_pkg.sv
rtl/core/fscf_front.sv
rtl/core/fscf_queue.sv
rtl/core/fscf_back.sv
rtl/core/fixed_size_chunk_framer.sv
bench/fixed_size_chunk_framer_tb.sv
